[src/s2io_pkg.sv]
// Shared types, codes and constants for the sector to image offset block.
package s2io_pkg;

  localparam int MAX_TRACKS_DEF = 128;
  localparam int SECTOR_W = 19;
  localparam int SKIP_W = 40;
  localparam int OFFS_W = 41;
  localparam int LEN_W = 12;
  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_SUB   = 2'd2,
    KIND_POS   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOTRACK = 2'd1,
    ST_NORAW   = 2'd2,
    ST_NOSUB   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    SZ_2048 = 3'd0,
    SZ_2324 = 3'd1,
    SZ_2336 = 3'd2,
    SZ_2352 = 3'd3,
    SZ_2448 = 3'd4
  } size_code_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_SCAN,
    BK_CALC,
    BK_MUL,
    BK_MSF,
    BK_DONE
  } back_state_t;

  // Query passed from front to back.
  typedef struct packed {
    kind_t                kind;
    logic [SECTOR_W-1:0]  sector;
    logic                 raw;
  } query_t;

  localparam int LBA_BIAS = 150;
  localparam int OFS_MODE1 = 16;
  localparam int OFS_MODE2 = 24;
  localparam int LEN_RAW = 2352;
  localparam int LEN_MODE2 = 2336;
  localparam int LEN_COOKED = 2048;
  localparam int LEN_SUB = 2448;

  function automatic logic [LEN_W-1:0] size_bytes(input logic [2:0] code);
    logic [LEN_W-1:0] b;
    case (code)
      SZ_2324: b = 12'd2324;
      SZ_2336: b = 12'd2336;
      SZ_2352: b = 12'd2352;
      SZ_2448: b = 12'd2448;
      default: b = 12'd2048;
    endcase
    return b;
  endfunction

endpackage

[src/s2io_front.sv]
// Front part: accepts commands, writes the track table, queues queries.
module s2io_front #(
  parameter int MAX_TRACKS = s2io_pkg::MAX_TRACKS_DEF,
  parameter int IDX_W = $clog2(MAX_TRACKS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic [6:0]                    in_entry_index,
  input  logic [s2io_pkg::SECTOR_W-1:0] in_entry_start,
  input  logic [s2io_pkg::SKIP_W-1:0]   in_entry_skip,
  input  logic [2:0]                    in_entry_size_code,
  input  logic                          in_entry_mode2,
  input  logic [7:0]                    in_entry_attr,
  input  logic [s2io_pkg::SECTOR_W-1:0] in_sector,
  input  logic                          in_raw,
  // table write port
  output logic                          tw_en,
  output logic [IDX_W-1:0]              tw_addr,
  output logic [s2io_pkg::SECTOR_W+s2io_pkg::SKIP_W+11:0] tw_data,
  // write acknowledge result
  output logic                          wr_ack,
  // queue to back
  output logic                          q_valid,
  output s2io_pkg::query_t              q_head,
  input  logic                          q_pop,
  input  logic                          back_busy,
  input  logic                          out_busy
);

  s2io_pkg::query_t  fifo_r [s2io_pkg::QDEPTH];
  logic              rd_ptr_r, rd_ptr_nxt, wr_ptr_r, wr_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              acc, push;

  // one item in flight at a time end to end
  assign busy = (cnt_r != 2'd0) || back_busy || out_busy;
  assign acc  = start && !busy;
  assign push = acc && (in_kind != s2io_pkg::KIND_WRITE);

  assign tw_en   = acc && (in_kind == s2io_pkg::KIND_WRITE) &&
                   (9'(in_entry_index) < 9'(MAX_TRACKS));
  assign tw_addr = IDX_W'(in_entry_index);
  assign tw_data = {in_entry_start, in_entry_skip, in_entry_size_code, in_entry_mode2,
                    in_entry_attr};
  assign wr_ack  = acc && (in_kind == s2io_pkg::KIND_WRITE);

  assign q_valid = cnt_r != 2'd0;
  assign q_head  = fifo_r[rd_ptr_r];

  // advance queue pointers
  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // hold queued payload
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{kind: s2io_pkg::kind_t'(in_kind), sector: in_sector, raw: in_raw};
    end
  end

endmodule

[src/s2io_back.sv]
// Back part: holds the track table, scans it and computes the result.
module s2io_back #(
  parameter int MAX_TRACKS = s2io_pkg::MAX_TRACKS_DEF,
  parameter int IDX_W = $clog2(MAX_TRACKS)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [7:0]                    track_count,
  input  logic                          tw_en,
  input  logic [IDX_W-1:0]              tw_addr,
  input  logic [s2io_pkg::SECTOR_W+s2io_pkg::SKIP_W+11:0] tw_data,
  input  logic                          q_valid,
  input  s2io_pkg::query_t              q_head,
  output logic                          q_pop,
  output logic                          back_busy,
  output logic                          res_valid,
  output logic [1:0]                    res_status,
  output logic [s2io_pkg::OFFS_W-1:0]   res_offset,
  output logic [s2io_pkg::LEN_W-1:0]    res_length,
  output logic [7:0]                    res_track,
  output logic [7:0]                    res_attr,
  output logic [6:0]                    res_am,
  output logic [5:0]                    res_as,
  output logic [6:0]                    res_af,
  output logic [6:0]                    res_rm,
  output logic [5:0]                    res_rs,
  output logic [6:0]                    res_rf
);
  localparam int DW = s2io_pkg::SECTOR_W + s2io_pkg::SKIP_W + 12;
  localparam int CW = IDX_W + 1;

  logic [DW-1:0] mem [MAX_TRACKS];
  logic [DW-1:0] rdata_r;
  logic [IDX_W-1:0] raddr;

  s2io_pkg::back_state_t st_r, st_nxt;
  s2io_pkg::query_t q_r;
  logic [CW-1:0] idx_r, idx_nxt, n_eff;
  logic [DW-1:0] cur_r, cur_nxt;
  logic [s2io_pkg::SECTOR_W-1:0] diff_r;
  logic [s2io_pkg::SKIP_W+s2io_pkg::LEN_W:0] prod_r;
  logic [s2io_pkg::SECTOR_W:0] absv_r, relv_r;
  logic [2:0] msf_cnt_r;
  logic load_q, hit;
  logic scan_wait_r;

  // effective table length
  always_comb begin
    if (CW'(track_count) > CW'(MAX_TRACKS)) n_eff = CW'(MAX_TRACKS);
    else n_eff = CW'(track_count);
  end

  logic [s2io_pkg::SECTOR_W-1:0] c_start, n_start;
  assign c_start = cur_r[DW-1 -: s2io_pkg::SECTOR_W];
  assign n_start = rdata_r[DW-1 -: s2io_pkg::SECTOR_W];
  assign hit = (c_start <= q_r.sector) && (q_r.sector < n_start);

  always_ff @(posedge clk) begin
    if (tw_en) mem[tw_addr] <= tw_data;
    rdata_r <= mem[raddr];
  end

  // back sequencer
  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    cur_nxt = cur_r;
    raddr = idx_r[IDX_W-1:0];
    q_pop = 1'b0;
    load_q = 1'b0;
    case (st_r)
      s2io_pkg::BK_IDLE: begin
        raddr = '0;
        idx_nxt = CW'(1);
        if (q_valid) begin
          q_pop = 1'b1;
          load_q = 1'b1;
          st_nxt = s2io_pkg::BK_READ;
        end
      end
      s2io_pkg::BK_READ: begin
        // entry 0 now in rdata; fetch entry 1
        cur_nxt = rdata_r;
        if (n_eff < CW'(2)) st_nxt = s2io_pkg::BK_DONE;
        else st_nxt = s2io_pkg::BK_SCAN;
      end
      s2io_pkg::BK_SCAN: begin
        // hold the address and the decision in the wait cycle
        if (scan_wait_r) st_nxt = s2io_pkg::BK_SCAN;
        else if (hit) st_nxt = s2io_pkg::BK_CALC;
        else if (idx_r + CW'(1) >= n_eff) st_nxt = s2io_pkg::BK_DONE;
        else begin
          cur_nxt = rdata_r;
          idx_nxt = idx_r + CW'(1);
          raddr = idx_nxt[IDX_W-1:0];
          st_nxt = s2io_pkg::BK_SCAN;
        end
      end
      s2io_pkg::BK_CALC: st_nxt = s2io_pkg::BK_MUL;
      s2io_pkg::BK_MUL: st_nxt = s2io_pkg::BK_MSF;
      s2io_pkg::BK_MSF: if (msf_cnt_r == 3'd0) st_nxt = s2io_pkg::BK_DONE;
      s2io_pkg::BK_DONE: st_nxt = s2io_pkg::BK_IDLE;
      default: st_nxt = s2io_pkg::BK_IDLE;
    endcase
  end

  // scan uses read data of the address issued the cycle before
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= s2io_pkg::BK_IDLE;
      scan_wait_r <= 1'b0;
    end else begin
      scan_wait_r <= (st_r == s2io_pkg::BK_SCAN) && (st_nxt == s2io_pkg::BK_SCAN) &&
                     !scan_wait_r;
      if ((st_r == s2io_pkg::BK_SCAN) && scan_wait_r) st_r <= s2io_pkg::BK_SCAN;
      else st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_q) q_r <= q_head;
    if (!(st_r == s2io_pkg::BK_SCAN && scan_wait_r)) begin
      idx_r <= idx_nxt;
      cur_r <= cur_nxt;
    end
  end

  // result found flag kept for the done cycle
  logic found_r;
  always_ff @(posedge clk) begin
    if (st_r == s2io_pkg::BK_READ) found_r <= 1'b0;
    else if (st_r == s2io_pkg::BK_SCAN && !scan_wait_r && hit) found_r <= 1'b1;
  end

  // reciprocals for the MSF split: ceil(2^32 / 4500) and ceil(2^20 / 75)
  localparam logic [19:0] RCP_MIN = 20'd954438;
  localparam logic [13:0] RCP_SEC = 14'd13982;
  logic [39:0] am_prod, rm_prod;
  logic [26:0] as_prod, rs_prod;
  assign am_prod = absv_r * RCP_MIN;
  assign rm_prod = diff_r * RCP_MIN;
  assign as_prod = absv_r[12:0] * RCP_SEC;
  assign rs_prod = relv_r[12:0] * RCP_SEC;

  // arithmetic: difference, product, MSF by reciprocal multiplication
  logic [s2io_pkg::LEN_W-1:0] sz;
  assign sz = s2io_pkg::size_bytes(cur_r[11:9]);
  logic [6:0] am_r, af_r, rm_r, rf_r;
  logic [5:0] as_r, rs_r;
  always_ff @(posedge clk) begin
    if (st_r == s2io_pkg::BK_CALC) begin
      diff_r <= q_r.sector - c_start;
      absv_r <= {1'b0, q_r.sector} + (s2io_pkg::SECTOR_W+1)'(s2io_pkg::LBA_BIAS);
    end
    if (st_r == s2io_pkg::BK_MUL) begin
      prod_r <= (s2io_pkg::SKIP_W+s2io_pkg::LEN_W+1)'(diff_r * sz);
      relv_r <= {1'b0, diff_r};
      am_r <= am_prod[38:32];
      rm_r <= rm_prod[38:32];
      msf_cnt_r <= 3'd2;
    end
    if (st_r == s2io_pkg::BK_MSF) begin
      // strip minutes, then split seconds, then take frames, one step per cycle
      msf_cnt_r <= msf_cnt_r - 3'd1;
      case (msf_cnt_r)
        3'd2: begin
          absv_r <= absv_r - 20'(am_r) * 20'd4500;
          relv_r <= relv_r - 20'(rm_r) * 20'd4500;
        end
        3'd1: begin
          as_r <= as_prod[25:20];
          rs_r <= rs_prod[25:20];
        end
        default: begin
          af_r <= 7'(absv_r[12:0] - 13'(as_r) * 13'd75);
          rf_r <= 7'(relv_r[12:0] - 13'(rs_r) * 13'd75);
        end
      endcase
    end
  end

  // assemble result
  logic [s2io_pkg::OFFS_W-1:0] base;
  logic mode2;
  assign mode2 = cur_r[8];
  assign base = s2io_pkg::OFFS_W'(cur_r[s2io_pkg::SKIP_W+11:12]) +
                s2io_pkg::OFFS_W'(prod_r);
  always_comb begin
    res_valid = st_r == s2io_pkg::BK_DONE;
    res_status = s2io_pkg::ST_OK;
    res_offset = '0; res_length = '0; res_track = '0; res_attr = '0;
    res_am = '0; res_as = '0; res_af = '0; res_rm = '0; res_rs = '0; res_rf = '0;
    if (!found_r) res_status = s2io_pkg::ST_NOTRACK;
    else begin
      res_track = 8'(idx_r);
      res_attr = cur_r[7:0];
      case (q_r.kind)
        s2io_pkg::KIND_POS: begin
          res_am = am_r; res_as = as_r; res_af = af_r;
          res_rm = rm_r; res_rs = rs_r; res_rf = rf_r;
        end
        s2io_pkg::KIND_SUB: begin
          if (sz != 12'(s2io_pkg::LEN_SUB)) res_status = s2io_pkg::ST_NOSUB;
          else begin
            res_offset = base; res_length = 12'(s2io_pkg::LEN_SUB);
          end
        end
        default: begin
          if (q_r.raw && sz != 12'(s2io_pkg::LEN_RAW)) res_status = s2io_pkg::ST_NORAW;
          else if (q_r.raw) begin
            res_offset = base; res_length = 12'(s2io_pkg::LEN_RAW);
          end else if (mode2) begin
            res_offset = base + 41'(s2io_pkg::OFS_MODE2);
            res_length = 12'(s2io_pkg::LEN_MODE2);
          end else begin
            res_length = 12'(s2io_pkg::LEN_COOKED);
            res_offset = (sz == 12'(s2io_pkg::LEN_RAW)) ? base + 41'(s2io_pkg::OFS_MODE1)
                                                         : base;
          end
        end
      endcase
    end
  end

  assign back_busy = st_r != s2io_pkg::BK_IDLE;

endmodule

[src/sector_to_image_offset_core.sv]
// Top level of the sector to image offset block.
// Maps a CD sector to a byte offset in a track-based image, or to MSF positions.
// Usage: raise start with the in_ fields; the item is taken when busy is low.
// kind 0 writes one track table entry and answers with status ok, not queued.
// kinds 1..3 go through a two-entry queue to a back end that scans the
// table one entry at a time (one memory read port), then does a
// multiply and a three-step MSF split by reciprocal multiplication.
// One item is in work at a time; busy stays high until its result is out, so
// the next transfer comes in the cycle after the result at the earliest. Each
// result shows on the out_ ports for one cycle with out_valid high; the
// receiver cannot stall, so nothing is held back. cfg_we writes track_count;
// the user must write it only while idle, as the block does not enforce this.
// Reset sets track_count to 2 and empties the queue; the table contents are
// undefined until written.
module sector_to_image_offset_core #(
  parameter int MAX_TRACKS = s2io_pkg::MAX_TRACKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic [6:0]                    in_entry_index,
  input  logic [18:0]                   in_entry_start,
  input  logic [39:0]                   in_entry_skip,
  input  logic [2:0]                    in_entry_size_code,
  input  logic                          in_entry_mode2,
  input  logic [7:0]                    in_entry_attr,
  input  logic [18:0]                   in_sector,
  input  logic                          in_raw,
  input  logic                          cfg_we,
  input  logic [7:0]                    cfg_wdata,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [40:0]                   out_byte_offset,
  output logic [11:0]                   out_read_length,
  output logic [7:0]                    out_track_found,
  output logic [7:0]                    out_track_attr,
  output logic [6:0]                    out_abs_minute,
  output logic [5:0]                    out_abs_second,
  output logic [6:0]                    out_abs_frame,
  output logic [6:0]                    out_rel_minute,
  output logic [5:0]                    out_rel_second,
  output logic [6:0]                    out_rel_frame
);
  localparam int IDX_W = $clog2(MAX_TRACKS);
  localparam int DW = s2io_pkg::SECTOR_W + s2io_pkg::SKIP_W + 12;

  logic [7:0] track_count_r;
  logic tw_en, wr_ack, q_valid, q_pop, back_busy, res_valid;
  logic [IDX_W-1:0] tw_addr;
  logic [DW-1:0] tw_data;
  s2io_pkg::query_t q_head;
  logic [1:0] rs;
  logic [40:0] ro;
  logic [11:0] rl;
  logic [7:0] rt, ra;
  logic [6:0] am, af, rm, rf;
  logic [5:0] as_s, rs_s;

  always_ff @(posedge clk) begin
    if (!rst_n) track_count_r <= 8'd2;
    else if (cfg_we) track_count_r <= cfg_wdata;
  end

  s2io_front #(.MAX_TRACKS(MAX_TRACKS), .IDX_W(IDX_W)) u_front (
    .clk, .rst_n, .start, .busy, .in_kind, .in_entry_index, .in_entry_start,
    .in_entry_skip, .in_entry_size_code, .in_entry_mode2, .in_entry_attr,
    .in_sector, .in_raw, .tw_en, .tw_addr, .tw_data, .wr_ack, .q_valid, .q_head,
    .q_pop, .back_busy, .out_busy(out_valid)
  );

  s2io_back #(.MAX_TRACKS(MAX_TRACKS), .IDX_W(IDX_W)) u_back (
    .clk, .rst_n, .track_count(track_count_r), .tw_en, .tw_addr, .tw_data,
    .q_valid, .q_head, .q_pop, .back_busy, .res_valid, .res_status(rs),
    .res_offset(ro), .res_length(rl), .res_track(rt), .res_attr(ra),
    .res_am(am), .res_as(as_s), .res_af(af), .res_rm(rm), .res_rs(rs_s), .res_rf(rf)
  );

  // register the result for one cycle
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= res_valid || wr_ack;
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_status <= rs; out_byte_offset <= ro; out_read_length <= rl;
      out_track_found <= rt; out_track_attr <= ra;
      out_abs_minute <= am; out_abs_second <= as_s; out_abs_frame <= af;
      out_rel_minute <= rm; out_rel_second <= rs_s; out_rel_frame <= rf;
    end else begin
      out_status <= s2io_pkg::ST_OK; out_byte_offset <= '0; out_read_length <= '0;
      out_track_found <= '0; out_track_attr <= '0;
      out_abs_minute <= '0; out_abs_second <= '0; out_abs_frame <= '0;
      out_rel_minute <= '0; out_rel_second <= '0; out_rel_frame <= '0;
    end
  end

endmodule

[dv/sector_to_image_offset_core_test.sv]
// Self-checking testbench for the sector to image offset block.
module sector_to_image_offset_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import s2io_pkg::*;

  localparam int TRACKS = 128;
  localparam int STALL_LIMIT = 5000;
  localparam int SECTOR_TOP = 524287;

  typedef struct packed {
    kind_t       kind;
    logic [6:0]  idx;
    logic [18:0] first;
    logic [39:0] skip;
    logic [2:0]  code;
    logic        mode2;
    logic [7:0]  attr;
    logic [18:0] sector;
    logic        raw;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [40:0] offs;
    logic [11:0] len;
    logic [7:0]  trk;
    logic [7:0]  attr;
    logic [6:0]  a_min;
    logic [5:0]  a_sec;
    logic [6:0]  a_frm;
    logic [6:0]  r_min;
    logic [5:0]  r_sec;
    logic [6:0]  r_frm;
  } res_t;

  // Track table copy, expected results and mismatch count.
  class offset_scoreboard;
    logic [18:0] start_tab[TRACKS];
    logic [39:0] skip_tab[TRACKS];
    logic [2:0]  code_tab[TRACKS];
    logic        mode2_tab[TRACKS];
    logic [7:0]  attr_tab[TRACKS];
    int unsigned track_count = 2;
    res_t        pending[$];
    int          errors = 0;

    function int lookup(logic [18:0] s);
      int n;
      n = (track_count > TRACKS) ? TRACKS : track_count;
      if (n < 2) return -1;
      for (int i = 0; i + 1 < n; i++)
        if (start_tab[i] <= s && s < start_tab[i+1]) return i;
      return -1;
    endfunction

    function int unsigned sector_bytes(logic [2:0] c);
      case (c)
        SZ_2324: return 2324;
        SZ_2336: return 2336;
        SZ_2352: return 2352;
        SZ_2448: return 2448;
        default: return 2048;
      endcase
    endfunction

    function res_t predict_offset(req_t r);
      res_t e;
      int t;
      int unsigned sz, fr;
      logic [63:0] base;
      e = '0;
      e.status = ST_OK;
      if (r.kind == KIND_WRITE) begin
        start_tab[r.idx] = r.first;
        skip_tab[r.idx] = r.skip;
        code_tab[r.idx] = r.code;
        mode2_tab[r.idx] = r.mode2;
        attr_tab[r.idx] = r.attr;
        return e;
      end
      t = lookup(r.sector);
      if (t < 0) begin
        e.status = ST_NOTRACK;
        return e;
      end
      e.trk = 8'(t + 1);
      e.attr = attr_tab[t];
      if (r.kind == KIND_POS) begin
        fr = r.sector + 150;
        e.a_frm = 7'(fr % 75);
        e.a_sec = 6'((fr / 75) % 60);
        e.a_min = 7'((fr / 4500) & 127);
        fr = r.sector - start_tab[t];
        e.r_frm = 7'(fr % 75);
        e.r_sec = 6'((fr / 75) % 60);
        e.r_min = 7'((fr / 4500) & 127);
        return e;
      end
      sz = sector_bytes(code_tab[t]);
      base = 64'(skip_tab[t]) + 64'(r.sector - start_tab[t]) * 64'(sz);
      if (r.kind == KIND_SUB) begin
        if (sz != 2448) begin
          e.status = ST_NOSUB;
          return e;
        end
        e.offs = base[40:0];
        e.len = 12'd2448;
        return e;
      end
      // data read: raw needs stored 2352-byte sectors
      if (r.raw && sz != 2352) begin
        e.status = ST_NORAW;
        return e;
      end
      if (r.raw) e.len = 12'd2352;
      else if (mode2_tab[t]) begin
        e.len = 12'd2336;
        base += 24;
      end else begin
        e.len = 12'd2048;
        if (sz == 2352) base += 16;
      end
      e.offs = base[40:0];
      return e;
    endfunction

    function void note_input(req_t r);
      pending = {pending, predict_offset(r)};
    endfunction

    function void check_result(res_t got);
      res_t e;
      string bad;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      bad = "";
      if (got.status !== e.status) bad = {bad, " status"};
      if (got.offs !== e.offs) bad = {bad, " byte_offset"};
      if (got.len !== e.len) bad = {bad, " read_length"};
      if (got.trk !== e.trk) bad = {bad, " track_found"};
      if (got.attr !== e.attr) bad = {bad, " track_attr"};
      if ({got.a_min, got.a_sec, got.a_frm} !== {e.a_min, e.a_sec, e.a_frm})
        bad = {bad, " abs_msf"};
      if ({got.r_min, got.r_sec, got.r_frm} !== {e.r_min, e.r_sec, e.r_frm})
        bad = {bad, " rel_msf"};
      if (bad != "") begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: mismatch in%s", bad);
          $display("  expected %p", e);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_kind = '0;
  logic [6:0]  in_entry_index = '0;
  logic [18:0] in_entry_start = '0;
  logic [39:0] in_entry_skip = '0;
  logic [2:0]  in_entry_size_code = '0;
  logic        in_entry_mode2 = 0;
  logic [7:0]  in_entry_attr = '0;
  logic [18:0] in_sector = '0;
  logic        in_raw = 0;
  logic        cfg_we = 0;
  logic [7:0]  cfg_wdata = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [40:0] out_byte_offset;
  logic [11:0] out_read_length;
  logic [7:0]  out_track_found, out_track_attr;
  logic [6:0]  out_abs_minute, out_abs_frame, out_rel_minute, out_rel_frame;
  logic [5:0]  out_abs_second, out_rel_second;

  offset_scoreboard sb = new();
  int gap_pct = 0;
  int stall_cycles = 0;

  sector_to_image_offset_core u_top (
    .clk, .rst_n, .start, .busy, .in_kind, .in_entry_index, .in_entry_start,
    .in_entry_skip, .in_entry_size_code, .in_entry_mode2, .in_entry_attr,
    .in_sector, .in_raw, .cfg_we, .cfg_wdata, .out_valid, .out_status,
    .out_byte_offset, .out_read_length, .out_track_found, .out_track_attr,
    .out_abs_minute, .out_abs_second, .out_abs_frame, .out_rel_minute,
    .out_rel_second, .out_rel_frame
  );

  always #6 clk = ~clk;

  // Check every result transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result({status_t'(out_status), out_byte_offset, out_read_length,
                       out_track_found, out_track_attr, out_abs_minute,
                       out_abs_second, out_abs_frame, out_rel_minute,
                       out_rel_second, out_rel_frame});
  end

  // Abort when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Hold start low for a random number of cycles.
  task automatic sender_gap();
    while ($urandom_range(99) < gap_pct) begin
      start <= 0;
      @(posedge clk);
    end
  endtask

  // Present one item and wait for its transfer.
  task automatic send(req_t r);
    logic took;
    sender_gap();
    in_kind <= r.kind;
    in_entry_index <= r.idx;
    in_entry_start <= r.first;
    in_entry_skip <= r.skip;
    in_entry_size_code <= r.code;
    in_entry_mode2 <= r.mode2;
    in_entry_attr <= r.attr;
    in_sector <= r.sector;
    in_raw <= r.raw;
    start <= 1;
    // sample busy mid-cycle, where it is settled for the coming edge
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    sb.note_input(r);
  endtask

  // Wait until every expected result has come and the block is idle.
  task automatic drain();
    start <= 0;
    do @(posedge clk); while (sb.pending.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_track_count(logic [7:0] v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.track_count = v;
  endtask

  function automatic req_t random_item();
    req_t r;
    r.kind = kind_t'($urandom_range(3));
    r.idx = 7'($urandom);
    r.first = 19'($urandom);
    r.skip = 40'({$urandom, $urandom});
    r.code = 3'($urandom);
    r.mode2 = 1'($urandom);
    r.attr = 8'($urandom);
    r.sector = 19'($urandom);
    r.raw = 1'($urandom);
    return r;
  endfunction

  function automatic req_t write_item(int i, logic [18:0] s, logic [2:0] c,
                                      logic m, logic [7:0] a, logic [39:0] sk);
    req_t r;
    r = random_item();
    r.kind = KIND_WRITE;
    r.idx = 7'(i);
    r.first = s;
    r.code = c;
    r.mode2 = m;
    r.attr = a;
    r.skip = sk;
    return r;
  endfunction

  function automatic req_t query_item(kind_t k, logic [18:0] s, logic raw);
    req_t r;
    r = random_item();
    r.kind = k;
    r.sector = s;
    r.raw = raw;
    return r;
  endfunction

  // Write entries 0..k-1 with non-decreasing starts and random contents.
  task automatic build_tracks(int k);
    int unsigned cur, step;
    cur = ($urandom_range(3) == 0) ? 0 : $urandom_range(300);
    step = 520000 / k;
    for (int i = 0; i < k; i++) begin
      send(write_item(i, 19'(cur), 3'($urandom), 1'($urandom), 8'($urandom),
                      40'({$urandom, $urandom})));
      cur += ($urandom_range(9) == 0) ? 0 : $urandom_range(1, step);
      if (cur > SECTOR_TOP) cur = SECTOR_TOP;
    end
  endtask

  // Random writes and queries; query sectors mostly inside a real track, the rest noise.
  task automatic random_traffic(int k, int n);
    int j;
    int unsigned lo, hi, s;
    req_t r;
    for (int c = 0; c < n; c++) begin
      r = random_item();
      if ($urandom_range(99) < 6) begin
        r.kind = KIND_WRITE;
      end else begin
        if (r.kind == KIND_WRITE) r.kind = kind_t'($urandom_range(1, 3));
        if ($urandom_range(99) < 85 && k >= 2) begin
          j = $urandom_range(k - 2);
          lo = sb.start_tab[j];
          hi = sb.start_tab[j+1];
          if (hi > lo) begin
            case ($urandom_range(4))
              0: s = lo;
              1: s = hi - 1;
              default: s = $urandom_range(lo, hi - 1);
            endcase
            r.sector = 19'(s);
          end
        end
      end
      send(r);
      if (c == n / 2 && $urandom_range(1)) drain();
    end
  endtask

  initial begin
    int counts[10] = '{128, 2, 255, 0, 1, 3, 17, 60, 128, 200};
    int pcts[3] = '{0, 73, 34};
    int k;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // fill every entry once so no query touches an unwritten one
    build_tracks(TRACKS);

    // directed: small table with hand-picked tracks
    set_track_count(8'd4);
    send(write_item(0, 19'd10, SZ_2352, 1'b0, 8'hFF, 40'hFF_FFFF_FFFF));
    send(write_item(1, 19'd100, SZ_2448, 1'b1, 8'h00, 40'd0));
    send(write_item(2, 19'd200, SZ_2336, 1'b1, 8'h41, 40'd12345));
    send(write_item(3, 19'(SECTOR_TOP), 3'd7, 1'b0, 8'h80, 40'd0));
    send(query_item(KIND_DATA, 19'd0, 1'b0));
    send(query_item(KIND_DATA, 19'd10, 1'b0));
    send(query_item(KIND_DATA, 19'd99, 1'b1));
    send(query_item(KIND_SUB, 19'd150, 1'b0));
    send(query_item(KIND_SUB, 19'd50, 1'b0));
    send(query_item(KIND_DATA, 19'd200, 1'b1));
    send(query_item(KIND_DATA, 19'd300, 1'b0));
    send(query_item(KIND_DATA, 19'd120, 1'b0));
    send(query_item(KIND_POS, 19'(SECTOR_TOP - 1), 1'b0));
    send(query_item(KIND_POS, 19'd10, 1'b0));
    send(query_item(KIND_POS, 19'(SECTOR_TOP), 1'b0));
    send(query_item(KIND_SUB, 19'(SECTOR_TOP), 1'b0));
    send(write_item(3, 19'd400, 3'd5, 1'b0, 8'h80, 40'd0));
    send(write_item(2, 19'd200, 3'd6, 1'b0, 8'h41, 40'd0));
    send(query_item(KIND_DATA, 19'd399, 1'b0));
    send(query_item(KIND_DATA, 19'd400, 1'b0));

    // random phases over several table sizes and idle patterns
    for (int p = 0; p < 10; p++) begin
      gap_pct = pcts[p % 3];
      set_track_count(8'(counts[p]));
      k = (counts[p] > TRACKS) ? TRACKS : (counts[p] < 2 ? 2 : counts[p]);
      build_tracks(k);
      random_traffic(k, 100);
    end

    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

[filelist.f]
src/s2io_pkg.sv
src/s2io_front.sv
src/s2io_back.sv
src/sector_to_image_offset_core.sv
dv/sector_to_image_offset_core_test.sv
